[rtl/aei_pkg.sv]
`default_nettype none
package aei_pkg;

  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int ACC_W   = 24;
  localparam int SPD_W   = 32;
  localparam int DIST_W  = 40;
  localparam int COUNT_W = 16;
  localparam int PKT_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_TO_G = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PACKETS = 3'd4;
  localparam int                   REG_COUNT       = 5;

  localparam logic [15:0] SMOOTHING_RST   = 16'd6554;
  localparam logic [23:0] COUNTS_TO_G_RST = 24'd155151;
  localparam logic [15:0] TIME_STEP_RST   = 16'd1311;
  localparam logic [23:0] GRAVITY_RST     = 24'd642689;
  localparam logic [7:0]  CAL_PACKETS_RST = 8'd100;

  typedef struct packed {
    logic [15:0] smoothing;
    logic [23:0] counts_to_g;
    logic [15:0] time_step;
    logic [23:0] gravity;
    logic [7:0]  cal_packets;
  } aei_cfg_t;

endpackage
`default_nettype wire

[rtl/aei_ifs.sv]
`default_nettype none
interface aei_in_if import aei_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic                   last_in_packet;
  modport source(output valid, sample_x, sample_y, last_in_packet, input ready);
  modport sink(input valid, sample_x, sample_y, last_in_packet, output ready);
endinterface

interface aei_out_if import aei_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0]  accel_x;
  logic signed [ACC_W-1:0]  accel_y;
  logic signed [SPD_W-1:0]  speed_x;
  logic signed [SPD_W-1:0]  speed_y;
  logic signed [DIST_W-1:0] distance_x;
  logic signed [DIST_W-1:0] distance_y;
  modport source(output valid, accel_x, accel_y, speed_x, speed_y, distance_x, distance_y,
                 input ready);
  modport sink(input valid, accel_x, accel_y, speed_x, speed_y, distance_x, distance_y,
               output ready);
endinterface

interface aei_cfg_if import aei_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/aei_front.sv]
`default_nettype none
module aei_front import aei_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  aei_in_if.sink                      samples,
  output logic                        q_valid,
  input  wire logic                   q_pop,
  output logic [SAMPLE_BITS-1:0]      q_sx,
  output logic [SAMPLE_BITS-1:0]      q_sy,
  output logic                        q_last
);

  logic [SAMPLE_BITS-1:0] mem_x [2];
  logic [SAMPLE_BITS-1:0] mem_y [2];
  logic                   mem_l [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;

  assign samples.ready = (count != 2'd2);
  assign push          = samples.valid && samples.ready;
  assign q_valid       = (count != 2'd0);
  assign q_sx          = mem_x[rd_ptr];
  assign q_sy          = mem_y[rd_ptr];
  assign q_last        = mem_l[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_x[wr_ptr] <= samples.sample_x;
      mem_y[wr_ptr] <= samples.sample_y;
      mem_l[wr_ptr] <= samples.last_in_packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      if (push && !q_pop) count <= count + 2'd1;
      else if (!push && q_pop) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

[rtl/aei_div.sv]
`default_nettype none
module aei_div #(
  parameter int NW  = 44,
  parameter int DVW = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [NW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                done,
  output logic [NW-1:0]       quotient
);

  localparam int CW = $clog2(NW + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] dvs;
  logic [NW-1:0]  quo;
  logic [DVW:0]   r_sh;
  logic [DVW:0]   r_sub;
  logic           ge;

  assign r_sh     = {rem, quo[NW-1]};
  assign ge       = r_sh >= {1'b0, dvs};
  assign r_sub    = r_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? r_sub[DVW-1:0] : r_sh[DVW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/aei_back.sv]
`default_nettype none
module aei_back import aei_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire aei_cfg_t               cfg,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  input  wire logic [SAMPLE_BITS-1:0] q_sx,
  input  wire logic [SAMPLE_BITS-1:0] q_sy,
  input  wire logic                   q_last,
  aei_out_if.source                   results
);

  localparam int SB   = SAMPLE_BITS;
  localparam int FSW  = SB + 17;
  localparam int DW   = SB + 18;
  localparam int SUMW = SB + 32;
  localparam int AW   = (DW > SPD_W) ? DW : SPD_W;
  localparam int BW   = 26;
  localparam int PW   = AW + BW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CMUL   = 4'd1;
  localparam logic [3:0] S_CUSE   = 4'd2;
  localparam logic [3:0] S_CEND   = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DWAIT  = 4'd5;
  localparam logic [3:0] S_RMUL   = 4'd6;
  localparam logic [3:0] S_RUSE   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [2:0] OP_EMA   = 3'd0;
  localparam logic [2:0] OP_SCALE = 3'd1;
  localparam logic [2:0] OP_GRAV  = 3'd2;
  localparam logic [2:0] OP_DV    = 3'd3;
  localparam logic [2:0] OP_SPD   = 3'd4;
  localparam logic [2:0] OP_DIST  = 3'd5;

  localparam logic signed [PW-1:0] ACC_HI  = PW'(64'sd8388607);
  localparam logic signed [PW-1:0] ACC_LO  = PW'(-64'sd8388608);
  localparam logic signed [32:0]   SPD_HI  = 33'sd2147483647;
  localparam logic signed [32:0]   SPD_LO  = -33'sd2147483648;
  localparam logic signed [41:0]   DIST_HI = 42'sd549755813887;
  localparam logic signed [41:0]   DIST_LO = -42'sd549755813888;

  logic [3:0]              state;
  logic [2:0]              op;
  logic                    axis;
  logic [SB-1:0]           sx_r;
  logic [SB-1:0]           sy_r;
  logic                    last_r;
  logic                    seeded;
  logic                    running;
  logic [COUNT_W-1:0]      pair_count;
  logic [PKT_W-1:0]        packets_seen;
  logic [FSW-1:0]          filt [2];
  logic [SUMW-1:0]         fsum [2];
  logic signed [ACC_W-1:0] acc [2];
  logic signed [SPD_W-1:0] spd [2];
  logic signed [DIST_W-1:0] pos [2];
  logic signed [DW-1:0]    df_r;
  logic signed [31:0]      am_r;
  logic signed [31:0]      dv_r;
  logic signed [31:0]      t1_r;
  logic signed [PW-1:0]    prod;
  logic                    out_valid;

  logic [SB-1:0]           s_cur;
  logic [FSW-1:0]          f_cur;
  logic signed [DW-1:0]    diff;
  logic signed [AW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    sh16;
  logic signed [PW-1:0]    sh17;
  logic signed [PW-1:0]    sh24;
  logic [FSW-1:0]          nx;
  logic signed [DW-1:0]    df;
  logic [FSW-1:0]          f_seed;
  logic [FSW-1:0]          f_cal;
  logic [SUMW:0]           sum_add;
  logic [SUMW-1:0]         sum_next;
  logic signed [PW-1:0]    acc_sum;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [31:0]      t2;
  logic signed [41:0]      dist_sum;
  logic signed [DIST_W-1:0] dist_next;
  logic signed [32:0]      spd_sum;
  logic signed [SPD_W-1:0] spd_next;
  logic [PKT_W-1:0]        ps_inc;
  logic                    div_start;
  logic                    div_done;
  logic [SUMW-1:0]         div_quo;

  assign s_cur  = axis ? sy_r : sx_r;
  assign f_cur  = filt[axis];
  assign diff   = $signed({2'b00, s_cur, 16'b0}) - $signed({1'b0, f_cur});
  assign sh16   = prod >>> 16;
  assign sh17   = prod >>> 17;
  assign sh24   = prod >>> 24;
  assign nx     = f_cur + sh16[FSW-1:0];
  assign df     = $signed({1'b0, nx}) - $signed({1'b0, f_cur});
  assign f_seed = {1'b0, s_cur, 16'b0};
  assign f_cal  = (state == S_CUSE) ? nx : f_seed;

  // saturating calibration sum
  assign sum_add  = {1'b0, fsum[axis]} + (SUMW + 1)'(f_cal);
  assign sum_next = sum_add[SUMW] ? {SUMW{1'b1}} : sum_add[SUMW-1:0];

  assign ps_inc = (packets_seen == {PKT_W{1'b1}}) ? packets_seen : packets_seen + 1'b1;

  always_comb begin
    acc_sum = PW'(acc[axis]) + sh24;
    if (acc_sum > ACC_HI) acc_next = ACC_W'(ACC_HI);
    else if (acc_sum < ACC_LO) acc_next = ACC_W'(ACC_LO);
    else acc_next = acc_sum[ACC_W-1:0];
  end

  always_comb begin
    t2       = sh17[31:0];
    dist_sum = 42'(pos[axis]) + 42'(t1_r) + 42'(t2);
    if (dist_sum > DIST_HI) dist_next = DIST_HI[DIST_W-1:0];
    else if (dist_sum < DIST_LO) dist_next = DIST_LO[DIST_W-1:0];
    else dist_next = dist_sum[DIST_W-1:0];
    spd_sum = 33'(spd[axis]) + 33'(dv_r);
    if (spd_sum > SPD_HI) spd_next = SPD_HI[SPD_W-1:0];
    else if (spd_sum < SPD_LO) spd_next = SPD_LO[SPD_W-1:0];
    else spd_next = spd_sum[SPD_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    unique case (op)
      OP_EMA: begin
        mul_a = AW'(diff);
        mul_b = $signed({10'b0, cfg.smoothing});
      end
      OP_SCALE: begin
        mul_a = AW'(df_r);
        mul_b = $signed({2'b0, cfg.counts_to_g});
      end
      OP_GRAV: begin
        mul_a = AW'(acc[axis]);
        mul_b = $signed({2'b0, cfg.gravity});
      end
      OP_DV: begin
        mul_a = AW'(am_r);
        mul_b = $signed({10'b0, cfg.time_step});
      end
      OP_SPD: begin
        mul_a = AW'(spd[axis]);
        mul_b = $signed({10'b0, cfg.time_step});
      end
      OP_DIST: begin
        mul_a = AW'(dv_r);
        mul_b = $signed({10'b0, cfg.time_step});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_DSTART);

  aei_div #(.NW(SUMW), .DVW(COUNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (fsum[axis]),
    .divisor  (pair_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sx_r   <= q_sx;
      sy_r   <= q_sy;
      last_r <= q_last;
    end
    if (state == S_CMUL || state == S_RMUL) prod <= mul_a * mul_b;
    if (state == S_RUSE) begin
      unique case (op)
        OP_EMA:  df_r <= df;
        OP_GRAV: am_r <= sh16[31:0];
        OP_DV:   dv_r <= sh16[31:0];
        OP_SPD:  t1_r <= sh16[31:0];
        default: ;
      endcase
    end
    if (state == S_OUT && (!out_valid || results.ready)) begin
      results.accel_x    <= acc[0];
      results.accel_y    <= acc[1];
      results.speed_x    <= spd[0];
      results.speed_y    <= spd[1];
      results.distance_x <= pos[0];
      results.distance_y <= pos[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_EMA;
      axis         <= 1'b0;
      seeded       <= 1'b0;
      running      <= 1'b0;
      pair_count   <= '0;
      packets_seen <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        filt[i] <= '0;
        fsum[i] <= '0;
        acc[i]  <= '0;
        spd[i]  <= '0;
        pos[i]  <= '0;
      end
    end else begin
      if (results.ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            axis  <= 1'b0;
            op    <= OP_EMA;
            state <= running ? S_RMUL : S_CMUL;
          end
        end
        S_CMUL: begin
          if (!seeded) begin
            filt[axis] <= f_seed;
            fsum[axis] <= sum_next;
            axis       <= 1'b1;
            state      <= axis ? S_CEND : S_CMUL;
          end else begin
            state <= S_CUSE;
          end
        end
        S_CUSE: begin
          filt[axis] <= nx;
          fsum[axis] <= sum_next;
          axis       <= 1'b1;
          state      <= axis ? S_CEND : S_CMUL;
        end
        S_CEND: begin
          seeded <= 1'b1;
          axis   <= 1'b0;
          if (pair_count != {COUNT_W{1'b1}}) pair_count <= pair_count + 1'b1;
          if (last_r) packets_seen <= ps_inc;
          // a zero count still needs one packet, which ps_inc always covers
          state <= (last_r && ps_inc >= cfg.cal_packets) ? S_DSTART : S_IDLE;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            filt[axis] <= div_quo[FSW-1:0];
            if (axis) begin
              running <= 1'b1;
              state   <= S_IDLE;
            end else begin
              axis  <= 1'b1;
              state <= S_DSTART;
            end
          end
        end
        S_RMUL: state <= S_RUSE;
        S_RUSE: begin
          unique case (op)
            OP_EMA:   filt[axis] <= nx;
            OP_SCALE: acc[axis] <= acc_next;
            OP_DIST: begin
              pos[axis] <= dist_next;
              spd[axis] <= spd_next;
            end
            default: ;
          endcase
          if (op == OP_DIST) begin
            op    <= OP_EMA;
            axis  <= 1'b1;
            state <= axis ? S_OUT : S_RMUL;
          end else begin
            op    <= op + 3'd1;
            state <= S_RMUL;
          end
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid = out_valid;

endmodule
`default_nettype wire

[rtl/accel_ema_integrator_core.sv]
// channel   dir   transaction
// samples   in    sample_x, sample_y, last_in_packet
// results   out   accel, speed, distance for x and y (run phase only)
// cfg       in    register index and write data
//
// a two-entry queue takes samples while the sequencer works on the previous one
// calibration pair: S_CMUL, S_CUSE per axis; a seeding first pair skips S_CUSE;
// the packet end that closes calibration adds one divide per axis
// on the bit-serial average divider; synchronous reset clears control state
// run pair: S_RMUL then S_RUSE per product on the single shared multiplier
// a waiting result holds the sequencer only
`default_nettype none
module accel_ema_integrator_core import aei_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  aei_in_if.sink    samples,
  aei_out_if.source results,
  aei_cfg_if.sink   cfg
);

  aei_cfg_t               cfg_regs;
  logic                   q_valid;
  logic                   q_pop;
  logic [SAMPLE_BITS-1:0] q_sx;
  logic [SAMPLE_BITS-1:0] q_sy;
  logic                   q_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.smoothing   <= SMOOTHING_RST;
      cfg_regs.counts_to_g <= COUNTS_TO_G_RST;
      cfg_regs.time_step   <= TIME_STEP_RST;
      cfg_regs.gravity     <= GRAVITY_RST;
      cfg_regs.cal_packets <= CAL_PACKETS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SMOOTHING:   cfg_regs.smoothing   <= cfg.data[15:0];
        REG_COUNTS_TO_G: cfg_regs.counts_to_g <= cfg.data;
        REG_TIME_STEP:   cfg_regs.time_step   <= cfg.data[15:0];
        REG_GRAVITY:     cfg_regs.gravity     <= cfg.data;
        REG_CAL_PACKETS: cfg_regs.cal_packets <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  aei_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_sx    (q_sx),
    .q_sy    (q_sy),
    .q_last  (q_last)
  );

  aei_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_sx    (q_sx),
    .q_sy    (q_sy),
    .q_last  (q_last),
    .results (results)
  );

endmodule
`default_nettype wire

[tb/sv/accel_ema_checker.sv]
module accel_ema_checker import aei_pkg::*; (
  input  logic clk,
  input  logic rst,
  aei_in_if    samples,
  aei_out_if   results,
  aei_cfg_if   cfg,
  output int   errors,
  output int   pending,
  output int   results_seen
);

  typedef struct {
    longint ax;
    longint ay;
    longint vx;
    longint vy;
    longint px;
    longint py;
  } motion_t;

  localparam longint SUM_LIMIT = (64'sd1 <<< (SAMPLE_BITS_DEF + 32)) - 1;
  localparam int     PAIR_LIMIT = 65535;

  motion_t motion_q[$];

  logic [15:0] smoothing;
  logic [23:0] counts_to_g;
  logic [15:0] time_step;
  logic [23:0] gravity;
  logic [7:0]  cal_packets;

  longint filt_x, filt_y, sum_x, sum_y;
  int     pairs, packets;
  bit     seeded, running;
  longint acc_x, acc_y, spd_x, spd_y, dist_x, dist_y;

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // >>> on a signed longint rounds toward minus infinity
  function automatic longint ema_next(longint f, longint s);
    longint diff;
    diff = (s <<< 16) - f;
    return f + ((diff * longint'(smoothing)) >>> 16);
  endfunction

  task automatic integrate(input longint df, inout longint acc, inout longint spd,
                           inout longint pos);
    longint dt;
    longint am;
    longint dv;
    dt  = longint'(time_step);
    acc = clamp(acc + ((df * longint'(counts_to_g)) >>> 24), ACC_W);
    am  = (acc * longint'(gravity)) >>> 16;
    dv  = (am * dt) >>> 16;
    pos = clamp(pos + ((spd * dt) >>> 16) + ((dv * dt) >>> 17), DIST_W);
    spd = clamp(spd + dv, SPD_W);
  endtask

  task automatic take_pair(input longint sx, input longint sy, input bit last);
    longint  nx;
    longint  ny;
    int      need;
    motion_t m;
    if (!running) begin
      if (!seeded) begin
        filt_x = sx <<< 16;
        filt_y = sy <<< 16;
        seeded = 1'b1;
      end else begin
        filt_x = ema_next(filt_x, sx);
        filt_y = ema_next(filt_y, sy);
      end
      sum_x = (sum_x + filt_x > SUM_LIMIT) ? SUM_LIMIT : sum_x + filt_x;
      sum_y = (sum_y + filt_y > SUM_LIMIT) ? SUM_LIMIT : sum_y + filt_y;
      if (pairs < PAIR_LIMIT) pairs++;
      if (last) begin
        need = (cal_packets == 0) ? 1 : int'(cal_packets);
        if (packets < 255) packets++;
        if (packets >= need) begin
          filt_x  = sum_x / pairs;
          filt_y  = sum_y / pairs;
          running = 1'b1;
        end
      end
    end else begin
      nx = ema_next(filt_x, sx);
      ny = ema_next(filt_y, sy);
      integrate(nx - filt_x, acc_x, spd_x, dist_x);
      integrate(ny - filt_y, acc_y, spd_y, dist_y);
      filt_x = nx;
      filt_y = ny;
      m.ax = acc_x;
      m.ay = acc_y;
      m.vx = spd_x;
      m.vy = spd_y;
      m.px = dist_x;
      m.py = dist_y;
      motion_q.push_back(m);
    end
  endtask

  task automatic check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      smoothing   <= SMOOTHING_RST;
      counts_to_g <= COUNTS_TO_G_RST;
      time_step   <= TIME_STEP_RST;
      gravity     <= GRAVITY_RST;
      cal_packets <= CAL_PACKETS_RST;
      filt_x = 0; filt_y = 0; sum_x = 0; sum_y = 0;
      pairs = 0; packets = 0; seeded = 0; running = 0;
      acc_x = 0; acc_y = 0; spd_x = 0; spd_y = 0; dist_x = 0; dist_y = 0;
      motion_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SMOOTHING:   smoothing   <= cfg.data[15:0];
          REG_COUNTS_TO_G: counts_to_g <= cfg.data;
          REG_TIME_STEP:   time_step   <= cfg.data[15:0];
          REG_GRAVITY:     gravity     <= cfg.data;
          REG_CAL_PACKETS: cal_packets <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        take_pair(longint'(samples.sample_x), longint'(samples.sample_y),
                  samples.last_in_packet);
      if (results.valid && results.ready) begin
        results_seen <= results_seen + 1;
        if (motion_q.size() == 0) begin
          errors++;
          $display("%0t result transaction with nothing expected", $time);
        end else begin
          check_field("accel_x", motion_q[0].ax, longint'(results.accel_x));
          check_field("accel_y", motion_q[0].ay, longint'(results.accel_y));
          check_field("speed_x", motion_q[0].vx, longint'(results.speed_x));
          check_field("speed_y", motion_q[0].vy, longint'(results.speed_y));
          check_field("distance_x", motion_q[0].px, longint'(results.distance_x));
          check_field("distance_y", motion_q[0].py, longint'(results.distance_y));
          void'(motion_q.pop_front());
        end
      end
    end
    pending <= motion_q.size();
  end

endmodule

[tb/sv/tb_accel_ema_integrator_core.sv]
module tb_accel_ema_integrator_core;
  import aei_pkg::*;

  logic clk;
  logic rst;
  int   errors, pending, results_seen;
  int   pairs_sent;
  bit   gaps_on;
  int   ready_hold;
  bit   stalls_on;

  aei_in_if  samples_if();
  aei_out_if results_if();
  aei_cfg_if cfg_if();

  accel_ema_integrator_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  accel_ema_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples_if),
    .results      (results_if),
    .cfg          (cfg_if),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      ready_hold <= 0;
      stalls_on <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      results_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stalls_on <= ~stalls_on;
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        ready_hold <= pick_gap();
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_pair(input logic [11:0] x, input logic [11:0] y, input bit last);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid          <= 1'b1;
    samples_if.sample_x       <= x;
    samples_if.sample_y       <= y;
    samples_if.last_in_packet <= last;
    do @(posedge clk); while (!samples_if.ready);
    pairs_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // calibration pairs give no result, so the closing divide needs extra settling time
  task automatic settle();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_run_cfg(input logic [15:0] w, input logic [23:0] k,
                               input logic [15:0] dt, input logic [23:0] g);
    write_reg(REG_SMOOTHING, {8'h0, w});
    write_reg(REG_COUNTS_TO_G, k);
    write_reg(REG_TIME_STEP, {8'h0, dt});
    write_reg(REG_GRAVITY, g);
  endtask

  initial begin
    rst = 1'b1;
    pairs_sent = 0;
    gaps_on = 1'b1;
    samples_if.valid <= 1'b0;
    samples_if.sample_x <= '0;
    samples_if.sample_y <= '0;
    samples_if.last_in_packet <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // calibration: one long back to back packet, then a few short ones
    write_reg(REG_CAL_PACKETS, 24'd255);
    write_reg(REG_SMOOTHING, 24'd20000);
    gaps_on = 1'b0;
    for (int i = 0; i < 300; i++)
      send_pair(12'($urandom_range(1500, 2600)), 12'($urandom_range(1500, 2600)),
                i == 299);
    gaps_on = 1'b1;
    for (int p = 0; p < 3; p++)
      for (int i = 0; i < 5; i++)
        send_pair(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), i == 4);
    settle();
    // lowering the packet count to zero closes calibration at the next packet end
    write_reg(REG_CAL_PACKETS, 24'd0);
    for (int i = 0; i < 4; i++)
      send_pair(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), i == 3);
    settle();

    // directed run pairs at the reset settings
    write_run_cfg(SMOOTHING_RST, COUNTS_TO_G_RST, TIME_STEP_RST, GRAVITY_RST);
    send_pair(12'd0, 12'd0, 1'b0);
    send_pair(12'd4095, 12'd4095, 1'b1);
    send_pair(12'd0, 12'd4095, 1'b0);
    send_pair(12'd4095, 12'd0, 1'b1);
    for (int i = 0; i < 8; i++)
      send_pair(i[0] ? 12'd4095 : 12'd0, i[0] ? 12'd0 : 12'd4095, i[1]);
    for (int i = 0; i < 8; i++)
      send_pair(12'hAAA ^ {12{i[0]}}, 12'h555 ^ {12{i[0]}}, i[0]);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_run_cfg(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
        1: write_run_cfg(16'h0, 24'h0, 16'h0, 24'h0);
        2: write_run_cfg(16'hFFFF, 24'hFFFFFF, 16'd1311, 24'd642689);
        default: write_run_cfg(16'($urandom_range(0, 65535)),
                               24'($urandom_range(0, 24'hFFFFFF)),
                               16'($urandom_range(0, 65535)),
                               24'($urandom_range(0, 24'hFFFFFF)));
      endcase
      write_reg(REG_CAL_PACKETS, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(3'(REG_COUNT + $urandom_range(0, 2)), 24'($urandom_range(0, 24'hFFFFFF)));
      for (int i = 0; i < 300; i++) begin
        if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        if (i == 150) begin
          samples_if.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_pair(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
      end
      settle();
    end

    $display("sent %0d sample pairs: long calibration packet, threshold lowered to zero,",
             pairs_sent);
    $display("directed extremes and six register settings; %0d results checked",
             results_seen);
    if (errors == 0 && pending == 0) begin
      $display("accel_ema_integrator_core: match");
    end else begin
      $display("accel_ema_integrator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("accel_ema_integrator_core: mismatch");
    $finish;
  end

endmodule
